// ----- rtl/plt_pkg.sv -----
// Shared constants, payload types and control types of the peer liveness rank table.
`default_nettype none
package plt_pkg;

	// Table geometry and time width.
	localparam int TABLE_ENTRIES = 255;
	localparam int TIME_BITS     = 48;
	localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
	localparam int ENTRY_W       = 2 * TIME_BITS;

	// Register reset and the held-rank marker for "no rank yet".
	localparam logic [15:0] RESET_PERIOD = 16'd10000;
	localparam logic [8:0]  NO_RANK      = 9'h1FF;

	// One heartbeat item.
	typedef struct packed {
		logic [7:0]           peer_index;
		logic [TIME_BITS-1:0] peer_clock;
		logic [TIME_BITS-1:0] now_ms;
	} in_item_t;

	// One result item.
	typedef struct packed {
		logic [7:0] alive_count;
		logic [7:0] own_rank;
		logic       rank_changed;
	} out_item_t;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_DRAIN,
		ST_REPORT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic read;
		logic report;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic sweep_last;
	} status_t;

endpackage
`default_nettype wire

// ----- rtl/plt_ram.sv -----
// Generic single-port RAM with a registered read.
`default_nettype none
module plt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    addr,
	input  wire logic [WIDTH-1:0] wdata,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read of the same address.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ----- rtl/plt_datapath.sv -----
// Datapath: peer table, valid bits, sweep counter, liveness test, counts and result register.
`default_nettype none
module plt_datapath import plt_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire cmd_t      cmd,
	output status_t        status,
	input  wire in_item_t  req,
	input  wire logic      cfg_we,
	input  wire logic [15:0] cfg_wdata,
	output logic           done,
	output out_item_t      result
);

	logic [15:0]          period_q;
	logic [TIME_BITS-1:0] stamp_q;
	logic [IDX_W-1:0]     addr_q;
	logic [IDX_W-1:0]     addr_s1;
	logic                 eval_s1;
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [CNT_W-1:0]     alive_q;
	logic [CNT_W-1:0]     rank_q;
	logic [8:0]           held_rank_q;
	logic                 done_q;
	out_item_t            result_q;

	logic                 in_range;
	logic                 ram_we;
	logic [IDX_W-1:0]     ram_addr;
	logic [ENTRY_W-1:0]   ram_wdata;
	logic [ENTRY_W-1:0]   ram_rdata;
	logic [TIME_BITS-1:0] rd_clock;
	logic [TIME_BITS-1:0] rd_seen;
	logic [TIME_BITS-1:0] new_stamp;
	logic [16:0]          window;
	logic                 live;
	logic                 ahead;
	logic                 entry_valid;
	logic [7:0]           alive_sat;
	logic [7:0]           rank_sat;

	// Heartbeat stamp, saturating at the top of the time range.
	assign new_stamp = (&req.now_ms) ? req.now_ms : req.now_ms + TIME_BITS'(1);
	assign in_range  = ({1'b0, req.peer_index} < 9'(TABLE_ENTRIES));

	// The table is written on the heartbeat and read in order during the sweep.
	assign ram_we    = cmd.load && in_range;
	assign ram_addr  = cmd.load ? req.peer_index[IDX_W-1:0] : addr_q;
	assign ram_wdata = {req.peer_clock, new_stamp};

	plt_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign rd_clock = ram_rdata[ENTRY_W-1:TIME_BITS];
	assign rd_seen  = ram_rdata[TIME_BITS-1:0];

	// Liveness: stamp below last-seen plus twice the period, in one extra bit.
	assign window      = {period_q, 1'b0};
	assign live        = ({1'b0, rd_seen} + (TIME_BITS+1)'(window)) > {1'b0, stamp_q};
	assign ahead       = rd_clock >= stamp_q;
	assign entry_valid = valid_q[addr_s1];

	assign status.sweep_last = (addr_q == IDX_W'(TABLE_ENTRIES - 1));

	// Counts above 255 saturate.
	assign alive_sat = (alive_q > CNT_W'(255)) ? 8'd255 : alive_q[7:0];
	assign rank_sat  = (rank_q  > CNT_W'(255)) ? 8'd255 : rank_q[7:0];

	// Ping period register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= RESET_PERIOD;
		end else if (cfg_we) begin
			period_q <= cfg_wdata;
		end
	end

	// Sweep address, read pipeline, valid bits, counts and result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q      <= '0;
			addr_s1     <= '0;
			eval_s1     <= 1'b0;
			valid_q     <= '0;
			alive_q     <= '0;
			rank_q      <= '0;
			held_rank_q <= NO_RANK;
			done_q      <= 1'b0;
		end else begin
			eval_s1 <= cmd.read;
			addr_s1 <= addr_q;
			done_q  <= cmd.report;
			if (cmd.load) begin
				addr_q  <= '0;
				alive_q <= '0;
				rank_q  <= '0;
				if (in_range) begin
					valid_q[req.peer_index[IDX_W-1:0]] <= (req.peer_clock != '0);
				end
			end else if (cmd.read) begin
				addr_q <= addr_q + IDX_W'(1);
			end
			// An occupied entry is counted or, once expired, marked empty.
			if (eval_s1 && entry_valid) begin
				if (live) begin
					alive_q <= alive_q + CNT_W'(1);
					if (ahead) begin
						rank_q <= rank_q + CNT_W'(1);
					end
				end else begin
					valid_q[addr_s1] <= 1'b0;
				end
			end
			if (cmd.report) begin
				held_rank_q <= {1'b0, rank_sat};
			end
		end
	end

	// Stamp and result payload registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			stamp_q <= new_stamp;
		end
		if (cmd.report) begin
			result_q.alive_count  <= alive_sat;
			result_q.own_rank     <= rank_sat;
			result_q.rank_changed <= ({1'b0, rank_sat} != held_rank_q);
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule
`default_nettype wire

// ----- rtl/plt_ctrl.sv -----
// Controller: sequences the heartbeat write, the table sweep and the result.
`default_nettype none
module plt_ctrl import plt_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	input  wire status_t status,
	output logic         busy,
	output cmd_t         cmd
);

	state_t state_q;
	state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_SWEEP;
				end
			end
			ST_SWEEP: begin
				cmd.read = 1'b1;
				if (status.sweep_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_REPORT;
			end
			ST_REPORT: begin
				cmd.report = 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ----- rtl/peer_liveness_rank_table.sv -----
// The result strobes on done after start, through the heartbeat write, a sweep that reads one
// table entry per cycle through the single RAM port, a drain state, a report state and the
// registered done. A new item is taken only while idle, once the report is through.
// The receiver cannot stall; each result is shown for one cycle with done.
// Reset is asynchronous and active low: all entries read as empty at once through
// per-entry valid bits, the period returns to 10000 ms and no rank is held.
`default_nettype none
module peer_liveness_rank_table import plt_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire in_item_t    req,
	output logic             done,
	output out_item_t        result,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata
);

	cmd_t    cmd;
	status_t status;

	plt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.busy   (busy),
		.cmd    (cmd)
	);

	plt_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.done      (done),
		.result    (result)
	);

endmodule
`default_nettype wire
